@@ design/blifo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blifo_pkg
// Shared types and constants of the bounded LIFO stack: operation and status
// codes, request and result payloads, controller states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package blifo_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 7;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SHOW = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [WORD_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [WORD_W-1:0]  data_word;
    logic                      is_empty;
    logic                      is_full;
    logic [OCC_W-1:0]          occupancy;
    logic                      last;
  } rsp_t;

  typedef enum logic [1:0] {
    CST_IDLE = 2'd0,
    CST_READ = 2'd1,
    CST_SHOW = 2'd2
  } ctrl_state_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_zero;
  } dp_status_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic    wr_push;
    logic    fill_inc;
    logic    fill_dec;
    logic    rd_top;
    logic    rd_next;
    logic    emit_imm;
    status_e imm_status;
    logic    emit_rd;
    logic    emit_last;
  } dp_cmd_t;

endpackage

@@ design/blifo_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blifo_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module blifo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/blifo_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blifo_ctrl
// Controller: decodes each request and sequences the datapath through
// single reads and the top-to-bottom display walk.
// ----------------------------------------------------------------------------
module blifo_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  blifo_pkg::op_e         op_i,
  input  blifo_pkg::dp_status_t  stat_i,
  output blifo_pkg::dp_cmd_t     cmd_o,
  output logic                   busy
);

  import blifo_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = start && (state_q == CST_IDLE);
  assign busy   = (state_q != CST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CST_IDLE: begin
        if (accept && !stat_i.empty) begin
          if (op_i == OP_POP || op_i == OP_PEEK) begin
            state_d = CST_READ;
          end else if (op_i == OP_SHOW) begin
            state_d = CST_SHOW;
          end
        end
      end
      CST_READ: begin
        state_d = CST_IDLE;
      end
      CST_SHOW: begin
        if (stat_i.idx_zero) begin
          state_d = CST_IDLE;
        end
      end
      default: begin
        state_d = CST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.imm_status = STAT_OK;
    unique case (state_q)
      CST_IDLE: begin
        if (accept) begin
          cmd_o.emit_imm = 1'b1;
          unique case (op_i)
            OP_PUSH: begin
              if (stat_i.full) begin
                cmd_o.imm_status = STAT_OVER;
              end else begin
                cmd_o.wr_push  = 1'b1;
                cmd_o.fill_inc = 1'b1;
              end
            end
            OP_POP, OP_PEEK, OP_SHOW: begin
              if (stat_i.empty) begin
                cmd_o.imm_status = STAT_UNDER;
              end else begin
                // result is read from the store and emitted from the read or display state
                cmd_o.emit_imm = 1'b0;
                cmd_o.rd_top   = 1'b1;
                cmd_o.fill_dec = (op_i == OP_POP);
              end
            end
            default: begin
              cmd_o.emit_imm = 1'b0;
            end
          endcase
        end
      end
      CST_READ: begin
        cmd_o.emit_rd   = 1'b1;
        cmd_o.emit_last = 1'b1;
      end
      CST_SHOW: begin
        cmd_o.emit_rd   = 1'b1;
        cmd_o.emit_last = stat_i.idx_zero;
        cmd_o.rd_next   = !stat_i.idx_zero;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ design/blifo_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blifo_dp
// Datapath: word store, fill counter, display walk index and the result
// register with its strobe.
// ----------------------------------------------------------------------------
module blifo_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blifo_pkg::req_t       req_i,
  input  blifo_pkg::dp_cmd_t    cmd_i,
  output blifo_pkg::dp_status_t stat_o,
  output logic                  result_valid_o,
  output blifo_pkg::rsp_t       rsp_o
);

  import blifo_pkg::*;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] top_addr, rd_addr;
  logic [WORD_W-1:0] rdata;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;

  assign top_addr = ADDR_W'(fill_q - CNT_W'(1));
  assign rd_addr  = cmd_i.rd_next ? (idx_q - ADDR_W'(1)) : top_addr;

  blifo_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_push),
    .waddr_i (ADDR_W'(fill_q)),
    .wdata_i (req_i.push_value),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.rd_top || cmd_i.rd_next) begin
      idx_d = rd_addr;
    end
  end

  always_comb begin
    valid_d          = cmd_i.emit_imm || cmd_i.emit_rd;
    rsp_d            = rsp_q;
    rsp_d.is_empty   = (fill_d == '0);
    rsp_d.is_full    = (fill_d >= CNT_W'(DEPTH));
    rsp_d.occupancy  = OCC_W'(fill_d);
    if (cmd_i.emit_imm) begin
      rsp_d.status    = cmd_i.imm_status;
      rsp_d.data_word = '0;
      rsp_d.last      = 1'b1;
    end else if (cmd_i.emit_rd) begin
      rsp_d.status    = STAT_OK;
      rsp_d.data_word = rdata;
      rsp_d.last      = cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.full     = (fill_q >= CNT_W'(DEPTH));
  assign stat_o.idx_zero = (idx_q == '0);

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

@@ design/bounded_lifo_stack_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_top
// Bounded LIFO stack of 64 signed 32-bit words with push, pop, peek and
// top-to-bottom display.
//
// A request (req_i: operation, push_value) is taken on a rising edge with
// start high and busy low. Results appear on rsp_o for exactly one cycle,
// flagged by result_valid_o; the receiver must take each one when shown.
// Every result carries status, data_word, the empty/full flags and the
// occupancy after the step, and last on the final result of a request.
//
// Push, and any request refused for overflow or underflow, gives its
// result in the cycle after acceptance and busy stays low, so requests
// of that kind can follow every cycle. Pop and peek read the word store
// through its registered read port, then pass the result register, with
// busy high while the controller is in its read state. Display with N
// words held streams N results on consecutive cycles, one store read per
// cycle, with busy high until the bottom word is emitted.
//
// Reset clears the fill counter (stack empty) and the controller; the word
// store keeps no reset value and is only ever read below the fill count.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  blifo_pkg::req_t req_i,
  output logic            result_valid_o,
  output blifo_pkg::rsp_t rsp_o
);

  import blifo_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  blifo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.operation),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  blifo_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  // A display result that is not the last is always followed by another
  a_show_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !rsp_o.last |=> result_valid_o)
    else $error("display stream broke before its last word");

  // Every accepted request either answers next cycle or keeps the block busy
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_valid_o)
    else $error("accepted request produced neither result nor busy");

  // Overflow is only reported on a full stack
  a_over_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.status == STAT_OVER |-> rsp_o.is_full)
    else $error("overflow reported while stack not full");

endmodule
